[rtl/rpa_pkg.sv]
// Shared types, constants and a helper function for the packet airtime block.
`timescale 1ns / 1ps

package rpa_pkg;

    localparam int LEN_W     = 8;
    localparam int SF_W      = 4;
    localparam int BW_W      = 2;
    localparam int PRE_W     = 8;
    localparam int MARGIN_W  = 8;
    localparam int US_W      = 25;
    localparam int MS_W      = 15;
    localparam int TO_W      = 19;
    localparam int MAXP_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam int NUM_W     = 9;   // payload symbol numerator over four
    localparam int DIV_W     = 4;
    localparam int RECIP_W   = 14;
    localparam int RECIP_SH  = 16;
    localparam int BLK_W     = 7;
    localparam int NSYM_W    = 9;
    localparam int PRE_US_W  = 24;
    localparam int SHIFT_W   = 4;
    localparam int Q_W       = 29;

    // Reciprocals for floor division by 1000 on 25 and 29 bit values.
    localparam int MS_RECIP_W = 26;
    localparam int MS_RECIP_SH = 35;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 26'd34359739;
    localparam int TO_RECIP_W = 30;
    localparam int TO_RECIP_SH = 39;
    localparam logic [TO_RECIP_W-1:0] TO_RECIP = 30'd549755814;

    localparam logic [SF_W-1:0] SF_MIN = 4'd6;
    localparam logic [SF_W-1:0] SF_MAX = 4'd12;
    localparam logic [SF_W-1:0] SF_LDRO = 4'd11;

    localparam logic [MAXP_W-1:0] MAXP_LOW_SF  = 8'd242;
    localparam logic [MAXP_W-1:0] MAXP_MID_SF  = 8'd115;
    localparam logic [MAXP_W-1:0] MAXP_HIGH_SF = 8'd51;

    localparam logic [CFG_IDX_W-1:0] CFG_SF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd3;

    localparam logic [BW_W-1:0] BW_125 = 2'd0;
    localparam logic [BW_W-1:0] BW_250 = 2'd1;
    localparam logic [BW_W-1:0] BW_500 = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        LEN_OK       = 2'd0,
        LEN_EMPTY    = 2'd1,
        LEN_TOO_LONG = 2'd2
    } len_status_t;

    typedef struct packed {
        logic [SF_W-1:0]     spreading_factor;
        logic [BW_W-1:0]     bandwidth_code;
        logic [PRE_W-1:0]    preamble_symbols;
        logic [MARGIN_W-1:0] timeout_margin;
    } cfg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]  shift;
        logic [NUM_W-1:0]    num4;
        logic [DIV_W-1:0]    div_m1;
        logic [RECIP_W-1:0]  recip;
        logic [PRE_US_W-1:0] pre_us;
        logic [MARGIN_W-1:0] margin;
        logic [MAXP_W-1:0]   max_payload;
        len_status_t         status;
    } job_t;

    // ceil(2^16 / d) for the symbol block divisors 6 to 10
    function automatic logic [RECIP_W-1:0] recip_of(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] r;
        begin
            unique case (d)
                4'd6:    r = 14'd10923;
                4'd7:    r = 14'd9363;
                4'd8:    r = 14'd8192;
                4'd9:    r = 14'd7282;
                default: r = 14'd6554;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/rpa_front.sv]
// Front end: input register and per-item classification against the configuration.
`timescale 1ns / 1ps

module rpa_front
    import rpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [LEN_W-1:0] payload_length,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic             valid_reg;
    logic             valid_next;
    logic [LEN_W-1:0] len_reg;

    logic [SF_W-1:0]    sf;
    logic [SHIFT_W-1:0] bw_shift;
    logic [SHIFT_W-1:0] shift;
    logic [10:0]        pre_base;
    logic [9:0]         num_raw;
    logic [DIV_W-1:0]   div;
    logic [MAXP_W-1:0]  maxp;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (job_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            len_reg <= payload_length;
    end

    always_comb
    begin
        if (cfg.spreading_factor < SF_MIN)
            sf = SF_MIN;
        else if (cfg.spreading_factor > SF_MAX)
            sf = SF_MAX;
        else
            sf = cfg.spreading_factor;

        // log2 of microseconds per chip
        unique case (cfg.bandwidth_code)
            BW_250:  bw_shift = 4'd2;
            BW_500:  bw_shift = 4'd1;
            default: bw_shift = 4'd3;
        endcase
        shift = sf + bw_shift;

        pre_base = {1'b0, cfg.preamble_symbols, 2'b00} + 11'd17;
        num_raw  = {1'b0, len_reg, 1'b0} + 10'd6;
        div      = (sf >= SF_LDRO) ? sf - 4'd2 : sf;

        if (sf == 4'd7 || sf == 4'd8)
            maxp = MAXP_LOW_SF;
        else if (sf == 4'd9 || sf == 4'd10)
            maxp = MAXP_MID_SF;
        else
            maxp = MAXP_HIGH_SF;

        job.shift       = shift;
        job.num4        = (num_raw < {6'd0, sf}) ? '0 : NUM_W'(num_raw - {6'd0, sf});
        job.div_m1      = div - 4'd1;
        job.recip       = recip_of(div);
        job.pre_us      = {13'd0, pre_base} << (shift - 4'd2);
        job.margin      = cfg.timeout_margin;
        job.max_payload = maxp;
        if (len_reg == '0)
            job.status = LEN_EMPTY;
        else if (len_reg > maxp)
            job.status = LEN_TOO_LONG;
        else
            job.status = LEN_OK;
    end

endmodule

[rtl/rpa_queue.sv]
// Two-entry queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps

module rpa_queue
    import rpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic can_push,
    input  logic pop,
    output logic has_item,
    output job_t head
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign has_item = (count_reg != 2'd0);
    assign can_push = (count_reg != 2'd2) || pop;
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/rpa_back.sv]
// Back end: four-stage arithmetic pipeline ending in the output register.
`timescale 1ns / 1ps

module rpa_back
    import rpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  job_t                job,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [US_W-1:0]     airtime_us,
    output logic [MS_W-1:0]     air_ms,
    output logic [TO_W-1:0]     rx_wait_ms,
    output logic [MAXP_W-1:0]   max_payload,
    output logic [STATUS_W-1:0] length_status
);

    logic advance;

    // stage 1: payload symbol blocks
    logic                v1_reg;
    logic [BLK_W-1:0]    blocks_reg;
    logic [SHIFT_W-1:0]  shift1_reg;
    logic [PRE_US_W-1:0] pre1_reg;
    logic [MARGIN_W-1:0] margin1_reg;
    logic [MAXP_W-1:0]   maxp1_reg;
    len_status_t         status1_reg;

    // stage 2: airtime
    logic                v2_reg;
    logic [US_W-1:0]     air2_reg;
    logic [MARGIN_W-1:0] margin2_reg;
    logic [MAXP_W-1:0]   maxp2_reg;
    len_status_t         status2_reg;

    // stage 3: millisecond and margin products
    logic                v3_reg;
    logic [US_W-1:0]     air3_reg;
    logic [MS_W-1:0]     ms3_reg;
    logic [Q_W-1:0]      q3_reg;
    logic [MAXP_W-1:0]   maxp3_reg;
    len_status_t         status3_reg;

    // output register
    logic                out_valid_reg;
    logic [US_W-1:0]     air_out_reg;
    logic [MS_W-1:0]     ms_out_reg;
    logic [TO_W-1:0]     to_out_reg;
    logic [MAXP_W-1:0]   maxp_out_reg;
    len_status_t         status_out_reg;

    logic [NUM_W:0]                  num_ceil;
    logic [NUM_W+RECIP_W:0]          blk_prod;
    logic [NSYM_W-1:0]               nsym;
    logic [PRE_US_W-1:0]             sym_us;
    logic [US_W+MS_RECIP_W-1:0]      ms_prod;
    logic [US_W+MARGIN_W-1:0]        margin_prod;
    logic [Q_W+TO_RECIP_W-1:0]       to_prod;

    assign advance = !out_valid_reg || out_ready;
    assign job_pop = advance && job_valid;

    always_comb
    begin
        num_ceil    = {1'b0, job.num4} + {{(NUM_W-DIV_W+1){1'b0}}, job.div_m1};
        blk_prod    = num_ceil * job.recip;
        nsym        = NSYM_W'(9'd8 + 9'd5 * {2'b00, blocks_reg});
        sym_us      = {{(PRE_US_W-NSYM_W){1'b0}}, nsym} << shift1_reg;
        ms_prod     = air2_reg * MS_RECIP;
        margin_prod = air2_reg * margin2_reg;
        to_prod     = q3_reg * TO_RECIP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= job_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blocks_reg  <= blk_prod[RECIP_SH+BLK_W-1:RECIP_SH];
            shift1_reg  <= job.shift;
            pre1_reg    <= job.pre_us;
            margin1_reg <= job.margin;
            maxp1_reg   <= job.max_payload;
            status1_reg <= job.status;

            air2_reg    <= {1'b0, pre1_reg} + {1'b0, sym_us};
            margin2_reg <= margin1_reg;
            maxp2_reg   <= maxp1_reg;
            status2_reg <= status1_reg;

            air3_reg    <= air2_reg;
            ms3_reg     <= ms_prod[MS_RECIP_SH+MS_W-1:MS_RECIP_SH];
            q3_reg      <= margin_prod[US_W+MARGIN_W-1:4];
            maxp3_reg   <= maxp2_reg;
            status3_reg <= status2_reg;

            air_out_reg    <= air3_reg;
            ms_out_reg     <= ms3_reg;
            to_out_reg     <= to_prod[TO_RECIP_SH+TO_W-1:TO_RECIP_SH];
            maxp_out_reg   <= maxp3_reg;
            status_out_reg <= status3_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign airtime_us    = air_out_reg;
    assign air_ms        = ms_out_reg;
    assign rx_wait_ms    = to_out_reg;
    assign max_payload   = maxp_out_reg;
    assign length_status = status_out_reg;

endmodule

[rtl/radio_packet_airtime.sv]
// Top level of the radio packet airtime calculator.
//
// Usage:
//   Input channel in_valid/in_ready carries one payload_length per item.
//   Output channel out_valid/out_ready returns one result item per input:
//   airtime_us, air_ms, rx_wait_ms, max_payload and length_status.
//   Configuration is written via cfg_we/cfg_index/cfg_wdata, one register per
//   cycle, only while no item is in flight: the user's duty, not checked.
// Timing:
//   One item per cycle sustained while out_ready is held high. The
//   accepting edge loads the input register; the item then passes the
//   two-entry queue, three arithmetic stages (symbol block divide, airtime
//   sum, millisecond/margin products) and the output register holding the
//   timeout divide before out_valid rises.
// Reset:
//   Configuration returns to sf 7, 125 kHz, 8 preamble symbols, margin 2.0;
//   all in-flight items are dropped.
// Stall:
//   A stalled receiver freezes the arithmetic pipeline; the queue and input
//   register still absorb up to three further items before in_ready drops.
`timescale 1ns / 1ps

module radio_packet_airtime
    import rpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LEN_W-1:0]     payload_length,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [US_W-1:0]      airtime_us,
    output logic [MS_W-1:0]      air_ms,
    output logic [TO_W-1:0]      rx_wait_ms,
    output logic [MAXP_W-1:0]    max_payload,
    output logic [STATUS_W-1:0]  length_status
);

    cfg_t cfg_reg;
    logic front_valid;
    logic queue_can_push;
    job_t front_job;
    logic queue_has_item;
    logic queue_pop;
    job_t queue_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spreading_factor <= 4'd7;
            cfg_reg.bandwidth_code   <= BW_125;
            cfg_reg.preamble_symbols <= 8'd8;
            cfg_reg.timeout_margin   <= 8'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SF:     cfg_reg.spreading_factor <= cfg_wdata[SF_W-1:0];
                CFG_BW:     cfg_reg.bandwidth_code   <= cfg_wdata[BW_W-1:0];
                CFG_PRE:    cfg_reg.preamble_symbols <= cfg_wdata[PRE_W-1:0];
                CFG_MARGIN: cfg_reg.timeout_margin   <= cfg_wdata[MARGIN_W-1:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    rpa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .payload_length (payload_length),
        .job_valid      (front_valid),
        .job_ready      (queue_can_push),
        .job            (front_job)
    );

    rpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid && queue_can_push),
        .push_data (front_job),
        .can_push  (queue_can_push),
        .pop       (queue_pop),
        .has_item  (queue_has_item),
        .head      (queue_head)
    );

    rpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (queue_has_item),
        .job           (queue_head),
        .job_pop       (queue_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .airtime_us    (airtime_us),
        .air_ms        (air_ms),
        .rx_wait_ms    (rx_wait_ms),
        .max_payload   (max_payload),
        .length_status (length_status)
    );

endmodule

[rtl/rpa_checker.sv]
// Port-level checks for the radio packet airtime block, bound to the top level.
`timescale 1ns / 1ps

module rpa_checker
    import rpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [US_W-1:0]     airtime_us,
    input logic [MS_W-1:0]     air_ms,
    input logic [MAXP_W-1:0]   max_payload,
    input logic [STATUS_W-1:0] length_status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(airtime_us) && $stable(length_status))
        else $error("result item changed while stalled");

    a_ms_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({12'd0, air_ms} * 27'd1000 <= {2'd0, airtime_us})
                   && ({2'd0, airtime_us} < {12'd0, air_ms} * 27'd1000 + 27'd1000))
        else $error("air_ms is not airtime_us floored to milliseconds");

    a_min_air: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> airtime_us >= 25'd1568)
        else $error("airtime below the shortest possible packet");

    a_maxp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_payload == MAXP_LOW_SF) || (max_payload == MAXP_MID_SF)
                   || (max_payload == MAXP_HIGH_SF))
        else $error("max_payload outside its three values");

endmodule

bind radio_packet_airtime rpa_checker u_rpa_checker (.*);

[dv/radio_packet_airtime_tb.sv]
// Testbench for radio_packet_airtime: directed length table, then random lengths and settings.
`timescale 1ns / 1ps

module radio_packet_airtime_tb;
    import rpa_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIRECTED      = 24;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_PRINTS      = 40;

    typedef struct packed {
        logic [US_W-1:0]   us;
        logic [MS_W-1:0]   ms;
        logic [TO_W-1:0]   wait_ms;
        logic [MAXP_W-1:0] maxp;
        len_status_t       status;
    } airtime_t;

    typedef struct packed {
        logic [SF_W-1:0]     sf;
        logic [BW_W-1:0]     bw;
        logic [PRE_W-1:0]    pre;
        logic [MARGIN_W-1:0] margin;
        logic [LEN_W-1:0]    len;
        logic                typed;
        airtime_t            want;
    } length_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [LEN_W-1:0]     payload_length = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [US_W-1:0]      airtime_us;
    logic [MS_W-1:0]      air_ms;
    logic [TO_W-1:0]      rx_wait_ms;
    logic [MAXP_W-1:0]    max_payload;
    logic [STATUS_W-1:0]  length_status;

    // shadow of the block's registers, reset values
    logic [SF_W-1:0]     cur_sf = 4'd7;
    logic [BW_W-1:0]     cur_bw = BW_125;
    logic [PRE_W-1:0]    cur_pre = 8'd8;
    logic [MARGIN_W-1:0] cur_margin = 8'd32;

    airtime_t    expected_airtime[$];
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    length_row_t length_table [N_DIRECTED] = '{
        '{4'd7,  BW_125, 8'd8,   8'd32,  8'd0,   1'b1,
          '{25'd20736, 15'd20, 19'd41, 8'd242, LEN_EMPTY}},
        '{4'd7,  BW_125, 8'd8,   8'd32,  8'd255, 1'b1,
          '{25'd394496, 15'd394, 19'd788, 8'd242, LEN_TOO_LONG}},
        '{4'd7,  BW_125, 8'd8,   8'd32,  8'd242, 1'b0, '0},
        '{4'd7,  BW_125, 8'd8,   8'd32,  8'd243, 1'b0, '0},
        '{4'd7,  BW_125, 8'd8,   8'd32,  8'd1,   1'b0, '0},
        '{4'd6,  BW_500, 8'd0,   8'd0,   8'd1,   1'b1,
          '{25'd2208, 15'd2, 19'd0, 8'd51, LEN_OK}},
        '{4'd6,  BW_500, 8'd0,   8'd0,   8'd0,   1'b1,
          '{25'd1568, 15'd1, 19'd0, 8'd51, LEN_EMPTY}},
        '{4'd6,  BW_500, 8'd0,   8'd0,   8'd51,  1'b0, '0},
        '{4'd6,  BW_500, 8'd0,   8'd0,   8'd52,  1'b0, '0},
        '{4'd9,  BW_250, 8'd20,  8'd200, 8'd115, 1'b0, '0},
        '{4'd9,  BW_250, 8'd20,  8'd200, 8'd116, 1'b0, '0},
        '{4'd10, BW_250, 8'd20,  8'd200, 8'd128, 1'b0, '0},
        '{4'd11, 2'd3,   8'd3,   8'd16,  8'd2,   1'b0, '0},
        '{4'd11, 2'd3,   8'd3,   8'd16,  8'd200, 1'b0, '0},
        '{4'd12, BW_125, 8'd255, 8'd255, 8'd255, 1'b1,
          '{25'd17113088, 15'd17113, 19'd272739, 8'd51, LEN_TOO_LONG}},
        '{4'd12, BW_125, 8'd255, 8'd255, 8'd0,   1'b0, '0},
        '{4'd12, BW_125, 8'd255, 8'd255, 8'd2,   1'b0, '0},
        '{4'd0,  BW_125, 8'd8,   8'd32,  8'd51,  1'b0, '0},
        '{4'd0,  BW_125, 8'd8,   8'd32,  8'd52,  1'b0, '0},
        // sf above range plus fallback bandwidth: same as the sf 12 extreme
        '{4'd15, 2'd3,   8'd255, 8'd255, 8'd255, 1'b1,
          '{25'd17113088, 15'd17113, 19'd272739, 8'd51, LEN_TOO_LONG}},
        '{4'd5,  BW_250, 8'd100, 8'd64,  8'd10,  1'b0, '0},
        '{4'd13, BW_500, 8'd100, 8'd64,  8'd10,  1'b0, '0},
        '{4'd8,  BW_500, 8'd128, 8'd16,  8'd242, 1'b0, '0},
        '{4'd8,  BW_500, 8'd128, 8'd16,  8'd243, 1'b0, '0}
    };

    radio_packet_airtime dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .payload_length (payload_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .airtime_us     (airtime_us),
        .air_ms         (air_ms),
        .rx_wait_ms     (rx_wait_ms),
        .max_payload    (max_payload),
        .length_status  (length_status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic airtime_t predict_airtime(input logic [LEN_W-1:0] len);
        airtime_t          r;
        int                sf;
        int                num;
        int                den;
        int                blocks;
        longint unsigned   chip_us;
        longint unsigned   tsym;
        longint unsigned   pre_syms;
        longint unsigned   pre_us;
        longint unsigned   nsym;
        longint unsigned   air;
        longint unsigned   margin;
        begin
            sf = int'(cur_sf);
            if (sf < int'(SF_MIN)) sf = int'(SF_MIN);
            if (sf > int'(SF_MAX)) sf = int'(SF_MAX);
            case (cur_bw)
                BW_250:  chip_us = 4;
                BW_500:  chip_us = 2;
                default: chip_us = 8;
            endcase
            tsym = (64'd1 << sf) * chip_us;
            pre_syms = cur_pre;
            pre_us = (pre_syms * 4 + 17) * tsym / 4;
            num = 8 * int'(len) - 4 * sf + 28 + 16 - 20;
            if (num < 0) num = 0;
            den = 4 * (sf - ((sf >= int'(SF_LDRO)) ? 2 : 0));
            blocks = (num + den - 1) / den;
            nsym = 8 + longint'(blocks) * 5;
            air = pre_us + nsym * tsym;
            margin = cur_margin;
            r.us = air[US_W-1:0];
            r.ms = MS_W'(air / 1000);
            r.wait_ms = TO_W'((air * margin) / 16000);
            if (sf == 7 || sf == 8) r.maxp = MAXP_LOW_SF;
            else if (sf == 9 || sf == 10) r.maxp = MAXP_MID_SF;
            else r.maxp = MAXP_HIGH_SF;
            if (len == '0) r.status = LEN_EMPTY;
            else if (len > r.maxp) r.status = LEN_TOO_LONG;
            else r.status = LEN_OK;
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS)
                $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // results side: stall per the current pattern
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        airtime_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_airtime.size() == 0)
            begin
                report_mismatch("unexpected item", airtime_us, 0);
            end
            else
            begin
                want = expected_airtime.pop_front();
                results_checked++;
                if (airtime_us !== want.us)
                    report_mismatch("airtime_us", airtime_us, want.us);
                if (air_ms !== want.ms)
                    report_mismatch("air_ms", air_ms, want.ms);
                if (rx_wait_ms !== want.wait_ms)
                    report_mismatch("rx_wait_ms", rx_wait_ms, want.wait_ms);
                if (max_payload !== want.maxp)
                    report_mismatch("max_payload", max_payload, want.maxp);
                if (length_status !== want.status)
                    report_mismatch("length_status", length_status, want.status);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_length(input logic [LEN_W-1:0] len, input logic typed,
                               input airtime_t typed_want);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                in_valid <= 1'b0;
                payload_length <= LEN_W'($urandom);
                @(posedge clk);
            end
            in_valid <= 1'b1;
            payload_length <= len;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            expected_airtime.push_back(typed ? typed_want : predict_airtime(len));
        end
    endtask

    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            while (expected_airtime.size() != 0) @(posedge clk);
        end
    endtask

    task automatic apply_config(input logic [SF_W-1:0] sf, input logic [BW_W-1:0] bw,
                                input logic [PRE_W-1:0] pre,
                                input logic [MARGIN_W-1:0] margin);
        logic [CFG_DAT_W-1:0] junk;
        begin
            junk = CFG_DAT_W'($urandom);
            // upper write bits of the narrow registers carry junk
            cfg_we <= 1'b1;
            cfg_index <= CFG_SF;
            cfg_wdata <= {junk[7:4], sf};
            @(posedge clk);
            cfg_index <= CFG_BW;
            cfg_wdata <= {junk[5:0], bw};
            @(posedge clk);
            cfg_index <= CFG_PRE;
            cfg_wdata <= pre;
            @(posedge clk);
            cfg_index <= CFG_MARGIN;
            cfg_wdata <= margin;
            @(posedge clk);
            cfg_we <= 1'b0;
            cur_sf = sf;
            cur_bw = bw;
            cur_pre = pre;
            cur_margin = margin;
            settings_used++;
        end
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        logic [LEN_W-1:0] len;
        begin
            case ($urandom_range(9))
                0: len = 8'd0;
                1: len = 8'd255;
                2:
                begin
                    case ($urandom_range(5))
                        0: len = 8'd51;
                        1: len = 8'd52;
                        2: len = 8'd115;
                        3: len = 8'd116;
                        4: len = 8'd242;
                        default: len = 8'd243;
                    endcase
                end
                3: len = LEN_W'($urandom_range(1, 4));
                default: len = LEN_W'($urandom_range(0, 255));
            endcase
            return len;
        end
    endfunction

    initial
    begin
        logic [SF_W-1:0]     sf;
        logic [BW_W-1:0]     bw;
        logic [PRE_W-1:0]    pre;
        logic [MARGIN_W-1:0] margin;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (length_table[i].sf != cur_sf || length_table[i].bw != cur_bw ||
                length_table[i].pre != cur_pre || length_table[i].margin != cur_margin)
            begin
                drain_results();
                apply_config(length_table[i].sf, length_table[i].bw,
                             length_table[i].pre, length_table[i].margin);
            end
            send_length(length_table[i].len, length_table[i].typed, length_table[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            case (p)
                0: apply_config(4'd6, BW_500, 8'd0, 8'd0);
                1: apply_config(4'd12, BW_125, 8'd255, 8'd255);
                2: apply_config(4'd15, 2'd3, 8'd255, 8'd128);
                3: apply_config(4'd0, BW_250, 8'd1, 8'd1);
                default:
                begin
                    sf = ($urandom_range(9) < 8) ? SF_W'($urandom_range(6, 12))
                                                 : SF_W'($urandom_range(0, 15));
                    bw = BW_W'($urandom_range(0, 3));
                    pre = ($urandom_range(1) == 0) ? PRE_W'($urandom_range(0, 16))
                                                   : PRE_W'($urandom);
                    margin = MARGIN_W'($urandom);
                    apply_config(sf, bw, pre, margin);
                end
            endcase
            case (p % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 60;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 60;
                end
                default:
                begin
                    src_idle_pct = 31;
                    sink_stall_pct = 31;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (i == ITEMS_PER_PHASE / 2 && p % 3 == 2)
                    drain_results();
                send_length(pick_length(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d results over %0d register settings, lengths 0 to 255,",
                 results_checked, settings_used);
        $display("with free-running, sender-idle, receiver-stall and mixed handshake patterns.");
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rpa_pkg.sv
rtl/rpa_front.sv
rtl/rpa_queue.sv
rtl/rpa_back.sv
rtl/radio_packet_airtime.sv
rtl/rpa_checker.sv
dv/radio_packet_airtime_tb.sv
